[rtl/core/fbfm_pkg.sv]
// ----------------------------------------------------------------------------
// fbfm_pkg
// Shared types and constants of the buffer pool frame manager: frame table
// entry layout, request modes, result status codes and scan results.
// ----------------------------------------------------------------------------
package fbfm_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PIN_BITS   = 16;
    localparam int PAGE_W     = 24;
    localparam int STAMP_W    = 32;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int FIDX_W     = 4;
    localparam int CFG_W      = 5;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam logic [CFG_W-1:0]    CFG_RESET = CFG_W'(16);
    localparam logic [PIN_BITS-1:0] PIN_MAX   = {PIN_BITS{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_PIN   = 2'd0,
        MODE_UNPIN = 2'd1,
        MODE_DIRTY = 2'd2,
        MODE_CLEAN = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_BUF    = 2'd1,
        ST_ALL_PINNED = 2'd2
    } t_status;

    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic [PIN_BITS-1:0] pin;
        logic                dirty;
        logic [STAMP_W-1:0]  stamp;
    } t_entry;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  found_idx;
        t_entry            found_entry;
        logic              free_ok;
        logic [IDX_W-1:0]  free_idx;
        logic              vic_ok;
        logic [IDX_W-1:0]  vic_idx;
        logic              vic_dirty;
        logic [PAGE_W-1:0] vic_page;
    } t_scan_res;

    function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] cfg);
        logic [CFG_W+CNT_W-1:0] c;
        c = {{CNT_W{1'b0}}, cfg};
        if (c > (CFG_W + CNT_W)'(MAX_FRAMES)) begin
            return CNT_W'(MAX_FRAMES);
        end
        return c[CNT_W-1:0];
    endfunction

    function automatic logic [FIDX_W-1:0] to_fidx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+FIDX_W-1:0] w;
        w = {{FIDX_W{1'b0}}, idx};
        return w[FIDX_W-1:0];
    endfunction

endpackage

[rtl/core/fbfm_scan_track.sv]
// ----------------------------------------------------------------------------
// fbfm_scan_track
// Follows the frame table entries as they come out of the memory during a
// scan and keeps the first matching frame, the lowest free frame and the
// oldest unpinned frame.
// ----------------------------------------------------------------------------
module fbfm_scan_track
    import fbfm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_chk,
    input  logic [IDX_W-1:0]   i_idx,
    input  logic               i_vbit,
    input  t_entry             i_entry,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic [STAMP_W-1:0] i_counter,
    output t_scan_res          o_res
);

    logic               r_found;
    logic               r_free_ok;
    logic               r_vic_ok;
    logic [IDX_W-1:0]   r_found_idx;
    t_entry             r_found_entry;
    logic [IDX_W-1:0]   r_free_idx;
    logic [IDX_W-1:0]   r_vic_idx;
    logic               r_vic_dirty;
    logic [PAGE_W-1:0]  r_vic_page;
    logic [STAMP_W-1:0] r_best_age;

    logic [STAMP_W-1:0] age;
    logic               take_found;
    logic               take_free;
    logic               take_vic;

    assign age        = i_counter - i_entry.stamp;
    assign take_found = i_chk && i_vbit && (i_entry.page == i_page) && !r_found;
    assign take_free  = i_chk && !i_vbit && !r_free_ok;
    assign take_vic   = i_chk && i_vbit && (i_entry.pin == '0)
                        && (!r_vic_ok || (age > r_best_age));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_vic_ok  <= 1'b0;
        end else begin
            if (take_found) begin
                r_found <= 1'b1;
            end
            if (take_free) begin
                r_free_ok <= 1'b1;
            end
            if (take_vic) begin
                r_vic_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_found) begin
            r_found_idx   <= i_idx;
            r_found_entry <= i_entry;
        end
        if (take_free) begin
            r_free_idx <= i_idx;
        end
        if (take_vic) begin
            r_vic_idx   <= i_idx;
            r_vic_dirty <= i_entry.dirty;
            r_vic_page  <= i_entry.page;
            r_best_age  <= age;
        end
    end

    always_comb begin
        o_res.found       = r_found;
        o_res.found_idx   = r_found_idx;
        o_res.found_entry = r_found_entry;
        o_res.free_ok     = r_free_ok;
        o_res.free_idx    = r_free_idx;
        o_res.vic_ok      = r_vic_ok;
        o_res.vic_idx     = r_vic_idx;
        o_res.vic_dirty   = r_vic_dirty;
        o_res.vic_page    = r_vic_page;
    end

endmodule

[rtl/core/fifo_buffer_frame_manager_unit.sv]
// ----------------------------------------------------------------------------
// fifo_buffer_frame_manager_unit
// Frame table of a page buffer pool with first-in-first-out replacement and
// saturating pin counts.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (mode and page number in tdata), one
// result per request leaves on the m_axis channel. The active frame count is
// written through i_cfg_wr_en / i_cfg_wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this. Each
// request reads the frame table memory one entry per cycle over the active
// frames through the single read port of the table, then updates one entry
// and registers the result. A new request is accepted only once the previous
// one is finished: as soon as its result has moved into the output register,
// even while it still waits there. When the receiver stalls, the result is
// held, and a finished second request waits until the output register
// frees up.
// Reset clears all frame valid bits, the load counter and the output valid,
// and sets the active frame count to 16; the table memory is not cleared.
// ----------------------------------------------------------------------------
module fifo_buffer_frame_manager_unit
    import fbfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // mode[1:0], page_number[25:2], zero[31:26]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], frame_index[5:2], hit[6], fetch_needed[7],
    // writeback_needed[8], evicted_page[32:9], zero[39:33]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_W-1:0]      i_cfg_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_cfg;
    t_mode                 r_mode;
    logic [PAGE_W-1:0]     r_page;
    logic [CNT_W-1:0]      r_rd_idx, n_rd_idx;
    logic                  r_rd_pend, n_rd_pend;
    logic [IDX_W-1:0]      r_chk_idx;
    logic [MAX_FRAMES-1:0] r_valid;
    logic [STAMP_W-1:0]    r_load_cnt;
    t_entry                mem [MAX_FRAMES];
    t_entry                r_mem_q;

    t_status               r_res_status, n_res_status;
    logic [FIDX_W-1:0]     r_res_fidx, n_res_fidx;
    logic                  r_res_hit, n_res_hit;
    logic                  r_res_fetch, n_res_fetch;
    logic                  r_res_wb, n_res_wb;
    logic [PAGE_W-1:0]     r_res_ev, n_res_ev;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [CNT_W-1:0]      active_n;
    logic                  accept;
    logic                  issue;
    logic [IDX_W-1:0]      rd_addr;
    logic                  start;
    logic                  chk;
    t_scan_res             scan;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    t_entry                wr_data;
    logic                  load;
    logic                  out_load;

    assign active_n      = active_count(r_cfg);
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept;
    assign issue         = (r_state == S_SCAN) && (r_rd_idx < active_n);
    assign rd_addr       = r_rd_idx[IDX_W-1:0];
    assign chk           = (r_state == S_SCAN) && r_rd_pend;
    assign out_load      = (r_state == S_PUSH) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    fbfm_scan_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_chk     (chk),
        .i_idx     (r_chk_idx),
        .i_vbit    (r_valid[r_chk_idx]),
        .i_entry   (r_mem_q),
        .i_page    (r_page),
        .i_counter (r_load_cnt),
        .o_res     (scan)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_rd_idx  = r_rd_idx;
        n_rd_pend = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_rd_idx = '0;
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_rd_pend = issue;
                if (issue) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // decision and entry update
    always_comb begin
        n_res_status = ST_OK;
        n_res_fidx   = '0;
        n_res_hit    = 1'b0;
        n_res_fetch  = 1'b0;
        n_res_wb     = 1'b0;
        n_res_ev     = '0;
        wr_en        = 1'b0;
        wr_addr      = scan.found_idx;
        wr_data      = scan.found_entry;
        load         = 1'b0;
        if (r_state == S_DONE) begin
            if (r_mode != MODE_PIN) begin
                if (!scan.found) begin
                    n_res_status = ST_NOT_BUF;
                end else begin
                    n_res_fidx = to_fidx(scan.found_idx);
                    wr_en      = 1'b1;
                    unique case (r_mode)
                        MODE_UNPIN: begin
                            if (scan.found_entry.pin != '0) begin
                                wr_data.pin = scan.found_entry.pin - PIN_BITS'(1);
                            end
                        end
                        MODE_DIRTY: wr_data.dirty = 1'b1;
                        MODE_CLEAN: wr_data.dirty = 1'b0;
                        default:    wr_data = scan.found_entry;
                    endcase
                end
            end else if (scan.found) begin
                n_res_fidx = to_fidx(scan.found_idx);
                n_res_hit  = 1'b1;
                wr_en      = 1'b1;
                if (scan.found_entry.pin != PIN_MAX) begin
                    wr_data.pin = scan.found_entry.pin + PIN_BITS'(1);
                end
            end else if (scan.free_ok || scan.vic_ok) begin
                load          = 1'b1;
                wr_en         = 1'b1;
                wr_addr       = scan.free_ok ? scan.free_idx : scan.vic_idx;
                wr_data.page  = r_page;
                wr_data.pin   = PIN_BITS'(1);
                wr_data.dirty = 1'b0;
                wr_data.stamp = r_load_cnt;
                n_res_fidx    = to_fidx(wr_addr);
                n_res_fetch   = 1'b1;
                if (!scan.free_ok && scan.vic_dirty) begin
                    n_res_wb = 1'b1;
                    n_res_ev = scan.vic_page;
                end
            end else begin
                n_res_status = ST_ALL_PINNED;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_rd_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_valid     <= '0;
            r_load_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_idx  <= n_rd_idx;
            r_rd_pend <= n_rd_pend;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (load) begin
                r_valid[wr_addr] <= 1'b1;
                r_load_cnt       <= r_load_cnt + STAMP_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(s_axis_tdata[MODE_W-1:0]);
            r_page <= s_axis_tdata[MODE_W+PAGE_W-1:MODE_W];
        end
        if (issue) begin
            r_chk_idx <= rd_addr;
        end
        if (r_state == S_DONE) begin
            r_res_status <= n_res_status;
            r_res_fidx   <= n_res_fidx;
            r_res_hit    <= n_res_hit;
            r_res_fetch  <= n_res_fetch;
            r_res_wb     <= n_res_wb;
            r_res_ev     <= n_res_ev;
        end
        if (out_load) begin
            r_out_data <= {(OUT_DATA_W - STATUS_W - FIDX_W - 3 - PAGE_W)'(0),
                           r_res_ev, r_res_wb, r_res_fetch, r_res_hit,
                           r_res_fidx, r_res_status};
        end
    end

    // frame table memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_mem_q <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_valid_only_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (($past(r_valid) & ~r_valid) == '0))
        else $error("frame valid bit cleared");

    a_cnt_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_load_cnt != $past(r_load_cnt)) |-> $past(r_state == S_DONE))
        else $error("load counter moved outside entry update");

    a_wb_has_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[8]) |-> m_axis_tdata[7])
        else $error("writeback without fetch");
`endif

endmodule

[dv/fifo_buffer_frame_manager_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_buffer_frame_manager_unit_tb
// Self-checking bench for the buffer pool frame table. A queue-fed driver
// offers pin, unpin, dirty-mark and clean requests, a clocked monitor keeps
// its own copy of the frame table and compares every result against it.
// Runs cover empty pools, evictions with and without writeback, fully pinned
// pools, frame counts from zero to above the table size, long receiver stalls
// and pin counts raised and driven back down past zero.
// ----------------------------------------------------------------------------
module fifo_buffer_frame_manager_unit_tb;
    import fbfm_pkg::*;

    localparam int DRAIN_CYCLES = MAX_FRAMES + 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int POOL_MAX     = MAX_FRAMES + 3;

    // field order mirrors the tdata layout, lowest bits last
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        t_mode             mode;
    } t_page_request;

    typedef struct packed {
        logic [PAGE_W-1:0] evicted;
        logic              wb;
        logic              fetch;
        logic              hit;
        logic [FIDX_W-1:0] frame;
        t_status           status;
    } t_frame_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // mode[1:0], page_number[25:2], zero[31:26]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // status[1:0], frame_index[5:2], hit[6], fetch_needed[7],
    // writeback_needed[8], evicted_page[32:9], zero[39:33]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wr_data = '0;

    fifo_buffer_frame_manager_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // frame table shadow
    logic [PAGE_W-1:0]   slot_page  [MAX_FRAMES];
    logic                slot_valid [MAX_FRAMES];
    logic [PIN_BITS-1:0] slot_pins  [MAX_FRAMES];
    logic                slot_dirty [MAX_FRAMES];
    logic [STAMP_W-1:0]  slot_stamp [MAX_FRAMES];
    logic [STAMP_W-1:0]  load_count;
    logic [CFG_W-1:0]    pool_frames;

    t_page_request pending_requests[$];
    t_frame_result predicted_results[$];
    logic [PAGE_W-1:0] page_pool [POOL_MAX];

    int  requests_issued = 0;
    int  requests_taken  = 0;
    int  mismatch_count  = 0;
    int  quiet_cycles    = 0;
    int  send_idle_pct   = 0;
    int  recv_idle_pct   = 0;
    int  stalls_asked    = 0;
    int  stalls_served   = 0;
    int  hold_left       = 0;
    int  hits_seen = 0, loads_seen = 0, writebacks_seen = 0;
    int  pinned_out_seen = 0, not_buffered_seen = 0;
    bit  in_taken = 1'b0;
    bit  out_taken;
    t_page_request next_req;
    t_frame_result want, got;

    function automatic t_frame_result serve_request(input t_mode mode,
                                                    input logic [PAGE_W-1:0] page);
        t_frame_result      r;
        int                 n, found, target, k;
        logic [STAMP_W-1:0] age, best_age;
        r        = '0;
        n        = (pool_frames > MAX_FRAMES) ? MAX_FRAMES : int'(pool_frames);
        found    = -1;
        target   = -1;
        best_age = '0;
        for (k = n - 1; k >= 0; k--) begin
            if (slot_valid[k] && slot_page[k] == page) found = k;
        end
        if (mode != MODE_PIN) begin
            if (found < 0) begin
                r.status = ST_NOT_BUF;
                return r;
            end
            case (mode)
                MODE_UNPIN: begin
                    if (slot_pins[found] != '0)
                        slot_pins[found] = slot_pins[found] - PIN_BITS'(1);
                end
                MODE_DIRTY: slot_dirty[found] = 1'b1;
                default:    slot_dirty[found] = 1'b0;
            endcase
            r.frame = FIDX_W'(found);
            return r;
        end
        if (found >= 0) begin
            if (slot_pins[found] != PIN_MAX)
                slot_pins[found] = slot_pins[found] + PIN_BITS'(1);
            r.frame = FIDX_W'(found);
            r.hit   = 1'b1;
            return r;
        end
        for (k = n - 1; k >= 0; k--) begin
            if (!slot_valid[k]) target = k;
        end
        if (target < 0) begin
            // no free frame: oldest unpinned load goes, lowest index on a tie
            for (k = 0; k < n; k++) begin
                if (slot_pins[k] == '0) begin
                    age = load_count - slot_stamp[k];
                    if (target < 0 || age > best_age) begin
                        target   = k;
                        best_age = age;
                    end
                end
            end
            if (target < 0) begin
                r.status = ST_ALL_PINNED;
                return r;
            end
            r.wb      = slot_dirty[target];
            r.evicted = slot_dirty[target] ? slot_page[target] : '0;
        end
        slot_page[target]  = page;
        slot_valid[target] = 1'b1;
        slot_pins[target]  = PIN_BITS'(1);
        slot_dirty[target] = 1'b0;
        slot_stamp[target] = load_count;
        load_count         = load_count + STAMP_W'(1);
        r.frame = FIDX_W'(target);
        r.fetch = 1'b1;
        return r;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_requests.pop_front();
                s_axis_tdata  <= IN_DATA_W'(next_req);
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (stalls_served != stalls_asked) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            stalls_served <= stalls_served + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor, shadow model and watchdog
    always @(posedge i_clk) begin
        in_taken  = s_axis_tvalid && s_axis_tready;
        out_taken = m_axis_tvalid && m_axis_tready;
        if (!i_rst_n) begin
            foreach (slot_valid[k]) begin
                slot_valid[k] = 1'b0;
                slot_pins[k]  = '0;
                slot_dirty[k] = 1'b0;
            end
            load_count  = '0;
            pool_frames = CFG_RESET;
        end else begin
            if (i_cfg_wr_en) pool_frames = i_cfg_wr_data;
            if (in_taken) begin
                next_req = t_page_request'(s_axis_tdata[$bits(t_page_request)-1:0]);
                predicted_results.push_back(serve_request(next_req.mode, next_req.page));
                requests_taken++;
            end
            if (out_taken) begin
                if (predicted_results.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = predicted_results.pop_front();
                    got  = t_frame_result'(m_axis_tdata[$bits(t_frame_result)-1:0]);
                    if (got.status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.frame != want.frame) begin
                        $error("frame_index: expected %0d, got %0d", want.frame, got.frame);
                        mismatch_count++;
                    end
                    if (got.hit != want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        mismatch_count++;
                    end
                    if (got.fetch != want.fetch) begin
                        $error("fetch_needed: expected %0d, got %0d", want.fetch, got.fetch);
                        mismatch_count++;
                    end
                    if (got.wb != want.wb) begin
                        $error("writeback_needed: expected %0d, got %0d", want.wb, got.wb);
                        mismatch_count++;
                    end
                    if (got.evicted != want.evicted) begin
                        $error("evicted_page: expected %h, got %h", want.evicted, got.evicted);
                        mismatch_count++;
                    end
                    hits_seen         += want.hit;
                    loads_seen        += want.fetch;
                    writebacks_seen   += want.wb;
                    pinned_out_seen   += (want.status == ST_ALL_PINNED);
                    not_buffered_seen += (want.status == ST_NOT_BUF);
                end
            end
        end
        if (in_taken || out_taken) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_request(input t_mode mode, input logic [PAGE_W-1:0] page);
        t_page_request req;
        req.mode = mode;
        req.page = page;
        pending_requests.push_back(req);
        requests_issued++;
    endtask

    // wait until every request has its result, then let the pipeline settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (requests_taken != requests_issued || predicted_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic start_phase(input logic [CFG_W-1:0] frames, input int send_pct,
                               input int recv_pct);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= frames;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] frames, input int count,
                                    input int send_pct, input int recv_pct,
                                    input bit with_stall);
        int    pool_size, roll, k;
        t_mode mode;
        logic [PAGE_W-1:0] page;
        start_phase(frames, send_pct, recv_pct);
        pool_size = ((frames > MAX_FRAMES) ? MAX_FRAMES : int'(frames)) + 3;
        for (k = 0; k < pool_size; k++) page_pool[k] = PAGE_W'($urandom);
        if (with_stall) stalls_asked++;
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            mode = (roll < 35) ? MODE_PIN : (roll < 80) ? MODE_UNPIN :
                   (roll < 90) ? MODE_DIRTY : MODE_CLEAN;
            page = ($urandom_range(9) == 0) ? PAGE_W'($urandom)
                                            : page_pool[$urandom_range(pool_size - 1)];
            push_request(mode, page);
        end
    endtask

    logic [PAGE_W-1:0] sat_page;

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 21;
        recv_idle_pct = 48;

        // empty pool, loads, hit, dirty handling, unpin down to and below zero
        push_request(MODE_UNPIN, 24'h123456);
        push_request(MODE_DIRTY, 24'h123456);
        push_request(MODE_CLEAN, 24'h123456);
        push_request(MODE_PIN, 24'h000000);
        push_request(MODE_PIN, 24'hFFFFFF);
        push_request(MODE_PIN, 24'h000000);
        push_request(MODE_DIRTY, 24'hFFFFFF);
        push_request(MODE_CLEAN, 24'hFFFFFF);
        push_request(MODE_DIRTY, 24'h000000);
        repeat (3) push_request(MODE_UNPIN, 24'h000000);
        push_request(MODE_UNPIN, 24'hFFFFFF);
        push_request(MODE_DIRTY, 24'hFFFFFF);
        push_request(MODE_PIN, 24'hAAAAAA);
        push_request(MODE_PIN, 24'h555555);

        // two frames: dirty evictions, fully pinned pool, clean eviction
        start_phase(CFG_W'(2), 21, 48);
        push_request(MODE_PIN, 24'h000001);
        push_request(MODE_PIN, 24'h000002);
        push_request(MODE_PIN, 24'h000003);
        push_request(MODE_UNPIN, 24'h000001);
        push_request(MODE_PIN, 24'h000003);
        push_request(MODE_UNPIN, 24'h000003);
        push_request(MODE_PIN, 24'hAAAAAA);

        // no active frame
        start_phase(CFG_W'(0), 21, 48);
        push_request(MODE_PIN, 24'h000003);
        push_request(MODE_UNPIN, 24'h000003);

        // count above table size, page now held twice
        start_phase(CFG_W'(31), 21, 48);
        push_request(MODE_UNPIN, 24'hAAAAAA);
        push_request(MODE_PIN, 24'hAAAAAA);

        run_random_phase(CFG_W'(16), 300, 21, 48, 1'b1);
        run_random_phase(CFG_W'(1),  150, 21, 48, 1'b0);
        run_random_phase(CFG_W'(31), 250, 48, 21, 1'b1);
        run_random_phase(CFG_W'(3),  200, 48, 21, 1'b0);
        run_random_phase(CFG_W'(0),   50, 48, 21, 1'b0);
        run_random_phase(CFG_W'(16), 300, 0, 0, 1'b1);
        run_random_phase(CFG_W'(5),  200, 0, 0, 1'b0);
        run_random_phase(CFG_W'(17), 150, 0, 0, 1'b0);

        // single frame: pin count up, back down past zero, then evict
        start_phase(CFG_W'(1), 0, 0);
        sat_page = PAGE_W'($urandom);
        if (slot_valid[0]) repeat (int'(slot_pins[0])) push_request(MODE_UNPIN, slot_page[0]);
        push_request(MODE_PIN, sat_page);
        repeat (8) push_request(MODE_PIN, sat_page);
        repeat (11) push_request(MODE_UNPIN, sat_page);
        push_request(MODE_PIN, sat_page ^ 24'h000001);

        wait_drained();
        $display("%0d requests checked: %0d hits, %0d loads, %0d writebacks",
                 requests_taken, hits_seen, loads_seen, writebacks_seen);
        $display("%0d fully pinned, %0d not buffered, pool sizes 0 to 31, %0d mismatches",
                 pinned_out_seen, not_buffered_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/fbfm_pkg.sv
rtl/core/fbfm_scan_track.sv
rtl/core/fifo_buffer_frame_manager_unit.sv
dv/fifo_buffer_frame_manager_unit_tb.sv
